// ===== src/md5sh_pkg.sv =====
// ----------------------------------------------------------------------------
// md5sh_pkg
// Types, constants and round functions shared by the MD5 stream hasher.
// ----------------------------------------------------------------------------
`default_nettype none

package md5sh_pkg;

    localparam int BLOCK_BYTES = 64;
    localparam int LANES       = 4;
    localparam int ROUNDS      = 64;

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;

    localparam logic [5:0] FILL_LEN_START = 6'd56;
    localparam logic [5:0] FILL_LAST      = 6'd63;
    localparam logic [7:0] PAD_BYTE       = 8'h80;
    localparam logic [6:0] ROUND_LAST     = 7'd64;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       last;
    } t_in_item;

    typedef struct packed {
        logic [63:0] digest_high;
        logic [63:0] digest_low;
    } t_out_item;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PAD,
        S_COMP,
        S_FIN
    } t_state;

    function automatic logic [31:0] md5_k(input logic [5:0] idx);
        logic [31:0] k;
        unique case (idx)
            6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] md5_s(input logic [5:0] idx);
        logic [4:0] s;
        unique case ({idx[5:4], idx[1:0]})
            4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
            4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
            4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
            4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

    function automatic logic [3:0] md5_g(input logic [5:0] idx);
        logic [3:0] i4;
        logic [3:0] g;
        i4 = idx[3:0];
        unique case (idx[5:4])
            2'd0:    g = i4;
            2'd1:    g = 4'(i4 * 4'd5 + 4'd1);
            2'd2:    g = 4'(i4 * 4'd3 + 4'd5);
            2'd3:    g = 4'(i4 * 4'd7);
            default: g = i4;
        endcase
        return g;
    endfunction

    function automatic logic [31:0] md5_f(input logic [1:0] stage, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        unique case (stage)
            2'd0:    f = (b & c) | (~b & d);
            2'd1:    f = (b & d) | (c & ~d);
            2'd2:    f = b ^ c ^ d;
            2'd3:    f = c ^ (b | ~d);
            default: f = b ^ c ^ d;
        endcase
        return f;
    endfunction

endpackage

`default_nettype wire

// ===== src/md5sh_ram.sv =====
// ----------------------------------------------------------------------------
// md5sh_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module md5sh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_we,
    input  wire logic [$clog2(DEPTH)-1:0]         i_waddr,
    input  wire logic [WIDTH-1:0]                 i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0]         i_raddr,
    output logic      [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== src/md5_stream_hash.sv =====
// ----------------------------------------------------------------------------
// md5_stream_hash
// MD5 digest of a byte stream, one byte per input transaction.
// ----------------------------------------------------------------------------
// The input channel carries one byte per transaction; byte_valid = 0 allows
// an idle transaction or an empty message, and last ends the message. After
// a transaction with last set, the block pads the message, compresses the
// remaining one or two blocks and presents the 128-bit digest as one output
// transaction, then returns to the initial chaining values.
// A byte that does not fill a block leaves the input ready. The 64th byte of a
// block starts a compression: one memory read ahead, 64 rounds of the shared
// round unit fed by the block memory, and a final step to add into the
// chaining words. The input is not ready while a block is compressed.
// Padding writes one byte per cycle into the block memory.
// The block buffer is four byte-lane memories of 16 entries each.
// Reset loads the initial chaining values and clears the fill count and
// bit length at once; the block memory needs no clearing. A finished digest
// waits in an output register while the next message is taken; only the
// following digest waits for the receiver to take the previous one.
// ----------------------------------------------------------------------------
`default_nettype none

module md5_stream_hash (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire md5sh_pkg::t_in_item   i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output md5sh_pkg::t_out_item       o_out_data
);

    localparam int LANE_DEPTH = md5sh_pkg::BLOCK_BYTES / md5sh_pkg::LANES;
    localparam int LANE_AW    = $clog2(LANE_DEPTH);

    md5sh_pkg::t_state r_state, n_state;
    logic [31:0]       r_chain [4];
    logic [31:0]       n_chain [4];
    logic [31:0]       r_a, r_b, r_c, r_d;
    logic [31:0]       n_a, n_b, n_c, n_d;
    logic [5:0]        r_fill, n_fill;
    logic [63:0]       r_bitlen, n_bitlen;
    logic [6:0]        r_round, n_round;
    logic              r_finishing, n_finishing;
    logic              r_pad_first, n_pad_first;
    logic              r_len_phase, n_len_phase;
    logic              r_out_valid, n_out_valid;
    md5sh_pkg::t_out_item r_out_data, n_out_data;

    logic              in_fire;
    logic              out_free;
    logic              ram_we;
    logic [7:0]        ram_wdata;
    logic [LANE_AW-1:0] rd_addr;
    logic [7:0]        lane_q [md5sh_pkg::LANES];
    logic [31:0]       m_word;
    logic [5:0]        ap_idx;
    logic [31:0]       t_sum;
    logic [4:0]        rot;
    logic [31:0]       t_rot;
    logic              pad_len_now;
    logic [7:0]        pad_byte;
    logic [31:0]       sum_a, sum_b, sum_c, sum_d;

    assign o_in_ready = i_rst_n && (r_state == md5sh_pkg::S_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    assign rd_addr = md5sh_pkg::md5_g(r_round[5:0]);
    assign m_word  = {lane_q[3], lane_q[2], lane_q[1], lane_q[0]};
    assign ap_idx  = 6'(r_round - 7'd1);
    assign t_sum   = r_a + md5sh_pkg::md5_f(ap_idx[5:4], r_b, r_c, r_d)
                   + md5sh_pkg::md5_k(ap_idx) + m_word;
    assign rot     = md5sh_pkg::md5_s(ap_idx);
    assign t_rot   = (t_sum << rot) | (t_sum >> (6'd32 - {1'b0, rot}));

    assign pad_len_now = !r_pad_first
                      && (r_len_phase || (r_fill == md5sh_pkg::FILL_LEN_START));
    assign pad_byte    = r_pad_first ? md5sh_pkg::PAD_BYTE
                       : (pad_len_now ? r_bitlen[{r_fill[2:0], 3'b000} +: 8] : 8'h00);

    assign sum_a = r_chain[0] + r_a;
    assign sum_b = r_chain[1] + r_b;
    assign sum_c = r_chain[2] + r_c;
    assign sum_d = r_chain[3] + r_d;

    for (genvar ln = 0; ln < md5sh_pkg::LANES; ln++) begin : g_lane
        md5sh_ram #(
            .WIDTH (8),
            .DEPTH (LANE_DEPTH)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (ram_we && (r_fill[1:0] == 2'(ln))),
            .i_waddr (r_fill[5:2]),
            .i_wdata (ram_wdata),
            .i_raddr (rd_addr),
            .o_rdata (lane_q[ln])
        );
    end

    always_comb begin
        n_state     = r_state;
        n_chain     = r_chain;
        n_a         = r_a;
        n_b         = r_b;
        n_c         = r_c;
        n_d         = r_d;
        n_fill      = r_fill;
        n_bitlen    = r_bitlen;
        n_round     = r_round;
        n_finishing = r_finishing;
        n_pad_first = r_pad_first;
        n_len_phase = r_len_phase;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_data  = r_out_data;
        ram_we      = 1'b0;
        ram_wdata   = pad_byte;

        unique case (r_state)
            md5sh_pkg::S_IDLE: begin
                if (in_fire) begin
                    if (i_in_data.last) begin
                        n_finishing = 1'b1;
                        n_pad_first = 1'b1;
                        n_len_phase = 1'b0;
                        n_state     = md5sh_pkg::S_PAD;
                    end
                    if (i_in_data.byte_valid) begin
                        ram_we    = 1'b1;
                        ram_wdata = i_in_data.data_byte;
                        n_fill    = r_fill + 6'd1;
                        n_bitlen  = r_bitlen + 64'd8;
                        if (r_fill == md5sh_pkg::FILL_LAST) begin
                            n_state = md5sh_pkg::S_COMP;
                            n_round = '0;
                            n_a     = r_chain[0];
                            n_b     = r_chain[1];
                            n_c     = r_chain[2];
                            n_d     = r_chain[3];
                        end
                    end
                end
            end
            md5sh_pkg::S_PAD: begin
                ram_we      = 1'b1;
                n_fill      = r_fill + 6'd1;
                n_pad_first = 1'b0;
                if (pad_len_now) begin
                    n_len_phase = 1'b1;
                end
                if (r_fill == md5sh_pkg::FILL_LAST) begin
                    n_state = md5sh_pkg::S_COMP;
                    n_round = '0;
                    n_a     = r_chain[0];
                    n_b     = r_chain[1];
                    n_c     = r_chain[2];
                    n_d     = r_chain[3];
                end
            end
            md5sh_pkg::S_COMP: begin
                n_round = r_round + 7'd1;
                if (r_round != '0) begin
                    n_a = r_d;
                    n_d = r_c;
                    n_c = r_b;
                    n_b = r_b + t_rot;
                end
                if (r_round == md5sh_pkg::ROUND_LAST) begin
                    n_state = md5sh_pkg::S_FIN;
                end
            end
            md5sh_pkg::S_FIN: begin
                if (r_finishing && r_len_phase) begin
                    if (out_free) begin
                        n_out_valid            = 1'b1;
                        n_out_data.digest_low  = {sum_b, sum_a};
                        n_out_data.digest_high = {sum_d, sum_c};
                        n_chain[0]  = md5sh_pkg::IV_A;
                        n_chain[1]  = md5sh_pkg::IV_B;
                        n_chain[2]  = md5sh_pkg::IV_C;
                        n_chain[3]  = md5sh_pkg::IV_D;
                        n_bitlen    = '0;
                        n_finishing = 1'b0;
                        n_len_phase = 1'b0;
                        n_state     = md5sh_pkg::S_IDLE;
                    end
                end else begin
                    n_chain[0] = sum_a;
                    n_chain[1] = sum_b;
                    n_chain[2] = sum_c;
                    n_chain[3] = sum_d;
                    n_state    = r_finishing ? md5sh_pkg::S_PAD : md5sh_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = md5sh_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= md5sh_pkg::S_IDLE;
            r_chain[0]  <= md5sh_pkg::IV_A;
            r_chain[1]  <= md5sh_pkg::IV_B;
            r_chain[2]  <= md5sh_pkg::IV_C;
            r_chain[3]  <= md5sh_pkg::IV_D;
            r_fill      <= '0;
            r_bitlen    <= '0;
            r_finishing <= 1'b0;
            r_pad_first <= 1'b0;
            r_len_phase <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_chain     <= n_chain;
            r_fill      <= n_fill;
            r_bitlen    <= n_bitlen;
            r_finishing <= n_finishing;
            r_pad_first <= n_pad_first;
            r_len_phase <= n_len_phase;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a        <= n_a;
        r_b        <= n_b;
        r_c        <= n_c;
        r_d        <= n_d;
        r_round    <= n_round;
        r_out_data <= n_out_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

// ===== src/md5sh_checker.sv =====
// ----------------------------------------------------------------------------
// md5sh_checker
// Port-level checks for the MD5 stream hasher, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

module md5sh_checker (
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  i_in_valid,
    input wire logic                  o_in_ready,
    input wire md5sh_pkg::t_in_item   i_in_data,
    input wire logic                  o_out_valid,
    input wire logic                  i_out_ready,
    input wire md5sh_pkg::t_out_item  o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("Digest changed or dropped before its transaction completed.");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("Digest valid after reset.");

    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_data.last |=> !o_in_ready)
        else $error("Input taken right after the end of a message.");

    a_digest_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !$past(o_in_ready))
        else $error("Digest appeared while the input side was open.");

endmodule

bind md5_stream_hash md5sh_checker u_md5sh_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

`default_nettype wire

// ===== bench/tb_md5_stream_hash.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_md5_stream_hash
// Self-checking bench for the MD5 stream hasher.
// ----------------------------------------------------------------------------
// Messages of directed and random lengths are streamed one byte per input
// transaction. Lengths cluster around the one- and two-block padding
// boundaries, and idle transactions are mixed in. An MD5 model in the bench
// computes each digest as its last transaction is accepted. Every output
// transaction is checked against the oldest predicted digest. The sender
// idles in bursts, the receiver stalls on a rotating pattern, and some
// messages are held back until every earlier digest has arrived.
// ----------------------------------------------------------------------------

module tb_md5_stream_hash;

    localparam int CYCLE_LIMIT = 500000;

    typedef struct packed {
        logic                hold;
        md5sh_pkg::t_in_item item;
    } t_pending_byte;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    md5sh_pkg::t_in_item  in_data = '0;
    logic                 out_ready = 1'b0;
    logic                 o_in_ready;
    logic                 o_out_valid;
    md5sh_pkg::t_out_item o_out_data;

    t_pending_byte        byte_q[$];
    md5sh_pkg::t_out_item digest_q[$];

    logic [31:0] round_k [0:63];
    int          rot_s [0:15];
    logic [31:0] chain [0:3];
    logic [7:0]  blk [0:63];
    int          blk_fill;
    logic [63:0] msg_bits;

    int n_items;
    int n_msgs;
    int fails;
    int cycles;
    int gap_left;
    int burst_left;
    int rx_tick;

    md5_stream_hash dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void md5_restart();
        chain[0] = 32'h67452301;
        chain[1] = 32'hefcdab89;
        chain[2] = 32'h98badcfe;
        chain[3] = 32'h10325476;
        blk_fill = 0;
        msg_bits = '0;
    endfunction

    function automatic void md5_compress();
        logic [31:0] w [0:15];
        logic [31:0] a, b, c, d, f, t;
        int          n, g, s;
        for (n = 0; n < 16; n++) begin
            w[n] = {blk[4*n+3], blk[4*n+2], blk[4*n+1], blk[4*n]};
        end
        a = chain[0];
        b = chain[1];
        c = chain[2];
        d = chain[3];
        for (n = 0; n < 64; n++) begin
            case (n / 16)
                0: begin
                    f = (b & c) | (~b & d);
                    g = n;
                end
                1: begin
                    f = (b & d) | (c & ~d);
                    g = (5 * n + 1) % 16;
                end
                2: begin
                    f = b ^ c ^ d;
                    g = (3 * n + 5) % 16;
                end
                default: begin
                    f = c ^ (b | ~d);
                    g = (7 * n) % 16;
                end
            endcase
            t = a + f + round_k[n] + w[g];
            s = rot_s[(n / 16) * 4 + n % 4];
            a = d;
            d = c;
            c = b;
            b = b + ((t << s) | (t >> (32 - s)));
        end
        chain[0] = chain[0] + a;
        chain[1] = chain[1] + b;
        chain[2] = chain[2] + c;
        chain[3] = chain[3] + d;
    endfunction

    function automatic void md5_push(input logic [7:0] v);
        blk[blk_fill] = v;
        blk_fill++;
        if (blk_fill == 64) begin
            md5_compress();
            blk_fill = 0;
        end
    endfunction

    function automatic void md5_absorb(input md5sh_pkg::t_in_item it);
        logic [63:0]          len;
        md5sh_pkg::t_out_item dig;
        int                   n;
        if (it.byte_valid) begin
            msg_bits = msg_bits + 64'd8;
            md5_push(it.data_byte);
        end
        if (it.last) begin
            len = msg_bits;
            md5_push(8'h80);
            while (blk_fill != 56) begin
                md5_push(8'h00);
            end
            for (n = 0; n < 8; n++) begin
                md5_push(len[8*n +: 8]);
            end
            dig.digest_low  = {chain[1], chain[0]};
            dig.digest_high = {chain[3], chain[2]};
            digest_q.push_back(dig);
            md5_restart();
        end
    endfunction

    task automatic queue_byte(input logic [7:0] b, input logic v, input logic l,
                              input logic h);
        t_pending_byte p;
        p.hold = h;
        p.item.data_byte = b;
        p.item.byte_valid = v;
        p.item.last = l;
        byte_q.push_back(p);
        n_items++;
    endtask

    task automatic queue_message(input int len, input logic h);
        logic tail_valid;
        logic first;
        int   k;
        tail_valid = (len > 0) && ($urandom_range(0, 1) == 1);
        first = h;
        for (k = 0; k < len; k++) begin
            if ($urandom_range(0, 9) == 0) begin
                queue_byte(8'($urandom), 1'b0, 1'b0, first);
                first = 1'b0;
            end
            queue_byte(8'($urandom), 1'b1, tail_valid && (k == len - 1), first);
            first = 1'b0;
        end
        if (!tail_valid) begin
            queue_byte(8'($urandom), 1'b0, 1'b1, first);
        end
        n_msgs++;
    endtask

    task automatic sel_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35) begin
            gap_left = 0;
        end else if (r < 92) begin
            gap_left = $urandom_range(1, 12);
        end else begin
            gap_left = $urandom_range(40, 150);
        end
    endtask

    initial begin
        int sel;
        int len;
        round_k = '{
            32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
            32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
            32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
            32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
            32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
            32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
            32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
            32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
            32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
            32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
            32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
            32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
            32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
            32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
            32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
            32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
        };
        rot_s = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
        md5_restart();

        // An empty message, an idle transaction, and an empty message again.
        queue_byte(8'h00, 1'b0, 1'b1, 1'b0);
        queue_byte(8'hff, 1'b0, 1'b0, 1'b0);
        queue_byte(8'hff, 1'b0, 1'b1, 1'b0);
        // Single-byte messages at both extremes of the byte value.
        queue_byte(8'h00, 1'b1, 1'b1, 1'b0);
        queue_byte(8'hff, 1'b1, 1'b1, 1'b0);
        // A short message closed by a transaction without a byte, sent only
        // after every earlier digest has been taken.
        queue_byte(8'h61, 1'b1, 1'b0, 1'b1);
        queue_byte(8'h62, 1'b1, 1'b0, 1'b0);
        queue_byte(8'h00, 1'b0, 1'b0, 1'b0);
        queue_byte(8'h63, 1'b1, 1'b0, 1'b0);
        queue_byte(8'hff, 1'b0, 1'b1, 1'b0);
        queue_byte(8'hff, 1'b1, 1'b0, 1'b0);
        queue_byte(8'h00, 1'b1, 1'b0, 1'b0);
        queue_byte(8'haa, 1'b1, 1'b0, 1'b0);
        queue_byte(8'h55, 1'b1, 1'b1, 1'b0);
        n_msgs = 6;

        while (n_items < 1250 || n_msgs < 12) begin
            sel = $urandom_range(0, 99);
            if (sel < 45) begin
                len = $urandom_range(0, 20);
            end else if (sel < 75) begin
                len = 64 * $urandom_range(0, 1) + $urandom_range(55, 65);
            end else if (sel < 95) begin
                len = $urandom_range(21, 130);
            end else begin
                len = $urandom_range(131, 400);
            end
            queue_message(len, $urandom_range(0, 7) == 0);
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (byte_q.size() != 0 || in_valid) begin
            @(posedge i_clk);
        end
        while (digest_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (200) @(posedge i_clk);
        if (fails == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    always @(posedge i_clk) begin : drive_bytes
        logic          v_nxt;
        t_pending_byte p;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            gap_left = 0;
            burst_left = 1;
        end else begin
            v_nxt = in_valid;
            if (in_valid && o_in_ready) begin
                md5_absorb(in_data);
                v_nxt = 1'b0;
            end
            if (!v_nxt) begin
                if (gap_left != 0) begin
                    gap_left--;
                end else if (byte_q.size() != 0 &&
                             !(byte_q[0].hold && digest_q.size() != 0)) begin
                    p = byte_q.pop_front();
                    in_data <= p.item;
                    v_nxt = 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 48);
                        sel_gap();
                    end
                end
            end
            in_valid <= v_nxt;
        end
    end

    always @(posedge i_clk) begin : check_digests
        md5sh_pkg::t_out_item want;
        logic                 rdy;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
            rx_tick = 0;
        end else begin
            if (o_out_valid && out_ready) begin
                if (digest_q.size() == 0) begin
                    $error("unexpected digest %h", o_out_data);
                    fails++;
                end else begin
                    want = digest_q.pop_front();
                    if (o_out_data.digest_low !== want.digest_low) begin
                        $error("digest_low expected %h actual %h",
                               want.digest_low, o_out_data.digest_low);
                        fails++;
                    end
                    if (o_out_data.digest_high !== want.digest_high) begin
                        $error("digest_high expected %h actual %h",
                               want.digest_high, o_out_data.digest_high);
                        fails++;
                    end
                end
            end
            rx_tick++;
            case ((rx_tick >> 9) % 4)
                0: rdy = 1'b1;
                1: rdy = $urandom_range(0, 3) != 0;
                2: rdy = (rx_tick % 97) < 20;
                default: rdy = $urandom_range(0, 1) == 1;
            endcase
            out_ready <= rdy;
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

endmodule
